/* hdl/mpq_pkg.sv */
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int OP_W       = 1;
    localparam int VALUE_W    = 32;
    localparam int MAX_W      = 32;
    localparam int COUNT_W    = 7;
    localparam int ERR_W      = 2;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic  shift_in;    // insert new_value at its sorted place
        logic  shift_out;   // drop the head, move every entry up by one
        data_t new_value;
    } cell_cmd_t;

endpackage

/* hdl/mpq_cell.sv */
`timescale 1ns / 1ps

module mpq_cell (
    input  logic                  clk,
    input  mpq_pkg::cell_cmd_t    cmd,
    input  logic                  occupied,
    input  logic                  upper_ge,
    input  mpq_pkg::data_t        upper_value,
    input  mpq_pkg::data_t        lower_value,
    output mpq_pkg::data_t        value_reg,
    output logic                  ge
);

    mpq_pkg::data_t value_next;

    // Held value ranks at or above the new word; entries sit in descending order.
    assign ge = occupied && (value_reg >= cmd.new_value);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.shift_in && !ge)
        begin
            if (upper_ge)
                value_next = cmd.new_value;
            else
                value_next = upper_value;
        end
        else if (cmd.shift_out)
        begin
            value_next = lower_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* hdl/max_priority_queue.sv */
`timescale 1ns / 1ps

// Channel  | Handshake                   | Words carried
// ---------+-----------------------------+--------------------------------------------
// item     | item_valid / item_ready     | op, value
// result   | result_valid / result_ready | max_value, is_empty, held_count, error_code
//
// Each accepted item updates the chain of cells at the accept edge, and the result
// word is valid in the next cycle. A new item is taken in the same cycle that the
// pending result is taken, so the queue can run one item per clock while results
// are taken; the compare in every cell against the broadcast value sets that
// figure. Reset clears the count, error code and result valid flag; cell contents
// are not cleared. While a result stalls, item_ready drops and the cells hold.

module max_priority_queue (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [mpq_pkg::OP_W-1:0]     op,
    input  logic [mpq_pkg::VALUE_W-1:0]  value,

    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [mpq_pkg::MAX_W-1:0]    max_value,
    output logic                         is_empty,
    output logic [mpq_pkg::COUNT_W-1:0]  held_count,
    output logic [mpq_pkg::ERR_W-1:0]    error_code
);

    localparam int N = mpq_pkg::CAPACITY;

    mpq_pkg::count_t    count_reg, count_next;
    mpq_pkg::err_t      err_reg, err_next;
    logic               result_valid_reg;
    logic               accept;
    mpq_pkg::cell_cmd_t cmd;

    mpq_pkg::data_t     cell_value [N];
    logic [N-1:0]       cell_ge;
    logic [N-1:0]       cell_occupied;

    // Accept only when the result slot is free or being emptied this cycle.
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        cmd.new_value = mpq_pkg::data_t'(value);
        cmd.shift_in  = 1'b0;
        cmd.shift_out = 1'b0;
        count_next    = count_reg;
        err_next      = err_reg;
        if (accept)
        begin
            err_next = mpq_pkg::ERR_OK;
            case (mpq_pkg::op_t'(op))
                mpq_pkg::OP_INSERT:
                begin
                    if (count_reg == mpq_pkg::count_t'(N))
                        err_next = mpq_pkg::ERR_FULL;
                    else
                    begin
                        cmd.shift_in = 1'b1;
                        count_next   = count_reg + mpq_pkg::count_t'(1);
                    end
                end
                mpq_pkg::OP_REMOVE:
                begin
                    if (count_reg == '0)
                        err_next = mpq_pkg::ERR_EMPTY;
                    else
                    begin
                        cmd.shift_out = 1'b1;
                        count_next    = count_reg - mpq_pkg::count_t'(1);
                    end
                end
                default:
                begin
                    err_next = mpq_pkg::ERR_OK;
                end
            endcase
        end
    end

    // Chain of cells, head (largest) at index zero.
    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            assign cell_occupied[i] = mpq_pkg::count_t'(i) < count_reg;

            if (i == 0)
            begin : g_head
                mpq_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .occupied    (cell_occupied[i]),
                    .upper_ge    (1'b1),
                    .upper_value (cmd.new_value),
                    .lower_value (cell_value[(N > 1) ? 1 : 0]),
                    .value_reg   (cell_value[i]),
                    .ge          (cell_ge[i])
                );
            end
            else if (i == N - 1)
            begin : g_tail
                mpq_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .occupied    (cell_occupied[i]),
                    .upper_ge    (cell_ge[i-1]),
                    .upper_value (cell_value[i-1]),
                    .lower_value (cell_value[i]),
                    .value_reg   (cell_value[i]),
                    .ge          (cell_ge[i])
                );
            end
            else
            begin : g_mid
                mpq_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .occupied    (cell_occupied[i]),
                    .upper_ge    (cell_ge[i-1]),
                    .upper_value (cell_value[i-1]),
                    .lower_value (cell_value[i+1]),
                    .value_reg   (cell_value[i]),
                    .ge          (cell_ge[i])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            err_reg          <= mpq_pkg::ERR_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
            if (accept)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Result fields come straight from state; the cells hold while a result stalls.
    assign result_valid = result_valid_reg;
    assign max_value    = (count_reg != '0) ? mpq_pkg::MAX_W'(cell_value[0])
                                            : '0;
    assign is_empty     = (count_reg == '0);
    assign held_count   = mpq_pkg::COUNT_W'(count_reg);
    assign error_code   = err_reg;

endmodule
